// ----- src/aes256_pkg.sv -----
`default_nettype none
package aes256_pkg;

    localparam int KEY_BITS = 256;
    localparam int NK = KEY_BITS / 32;
    localparam int NR = NK + 6;
    localparam int RK_WORDS = 4 * (NR + 1);
    localparam int RKW_IDX_W = $clog2(RK_WORDS);
    localparam int RND_W = $clog2(NR + 1);
    localparam int BLOCK_BYTES = 16;

    typedef logic [7:0] sbox_tab_t [256];

    localparam sbox_tab_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IV_HIGH = 3'd4;
    localparam logic [2:0] REG_IV_LOW = 3'd5;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // state bytes: byte 0 in bits [127:120], column-major
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] all;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++)
                t[4*c + rr] = SBOX[b[4*((c + rr) % 4) + rr]];
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            o[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            o[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            o[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            o[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = mix ? o[i] : t[i];
        aes_round = r;
    endfunction

endpackage
`default_nettype wire

// ----- src/aes256_ctr_decrypt_top.sv -----
// AES-256 counter-mode decryption.
// Input stream s_axis_*: one ciphertext block per transaction; restart in
// tuser reloads the counter from the IV registers and expands the key.
// Output stream m_axis_*: one plaintext block per input block, same order;
// bytes past the valid-byte count in tdata are zero.
// Config port: cfg_we/cfg_addr/cfg_wdata, write only while idle; values are
// used at the next restart.
// Operation: a restart block first runs key expansion, one round-key word a
// cycle (8 key words copied, 52 expanded). Then the cipher loads the counter
// and runs the shared round unit once per cycle: initial key add plus 14
// rounds, each round's 128-bit round key read from the key memory into a
// register in the cycle before. The result goes to the output register when
// the last round ends. One block is in flight at a time; s_axis_tready is
// high only when idle and the output register is free. A stalled receiver
// holds the result in the output register and blocks further input.
// Reset clears the counter and control; the round-key memory is undefined
// until the first restart.
`default_nettype none
module aes256_ctr_decrypt_top
    import aes256_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // data_high, data_low, valid_bytes, pad
    input  wire logic         s_axis_tlast,  // last_block
    input  wire logic         s_axis_tuser,  // restart
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata,  // plain_high, plain_low, valid_bytes_out, pad
    output logic              m_axis_tlast   // last_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEXP = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] key_reg [4];
    logic [63:0] iv_hi_reg, iv_lo_reg;
    logic [127:0] ctr_reg;
    logic [127:0] data_reg;
    logic [4:0] nvb_reg;
    logic last_reg;

    // one 128-bit round key per entry, word 0 in the top lane
    logic [3:0][31:0] rk_mem [NR+1];
    logic [127:0] rk_rd_reg;

    // key expansion: sliding window of last NK words
    logic [31:0] win_reg [NK];
    logic [RKW_IDX_W:0] kidx_reg;
    logic [7:0] rcon_reg;
    logic [RND_W:0] rnd_reg;
    logic [127:0] st_reg;

    logic [135:0] out_data_reg;
    logic out_last_reg, out_valid_reg;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            iv_hi_reg <= '0;
            iv_lo_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[cfg_addr[1:0]] <= cfg_wdata;
                REG_IV_HIGH: iv_hi_reg <= cfg_wdata;
                REG_IV_LOW:  iv_lo_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next expanded word
    logic [31:0] kw_new, kt;
    logic [RKW_IDX_W:0] kmod;
    always_comb begin
        kmod = (RKW_IDX_W+1)'(kidx_reg % NK);
        kt = win_reg[NK-1];
        if (kmod == '0)
            kt = sub_word({kt[23:0], kt[31:24]}) ^ {rcon_reg, 24'h0};
        else if (NK > 6 && kmod == (RKW_IDX_W+1)'(4))
            kt = sub_word(kt);
        kw_new = win_reg[0] ^ kt;
    end

    logic [127:0] rnd_out;
    assign rnd_out = aes_round(st_reg, rnd_reg != (RND_W+1)'(NR));

    // round key read one round ahead
    logic [RND_W-1:0] rnd_next_idx;

    always_comb begin
        state_next = state_reg;
        rnd_next_idx = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = s_axis_tuser ? ST_KEXP : ST_LOAD;
            end
            ST_KEXP: begin
                if (kidx_reg == (RKW_IDX_W+1)'(RK_WORDS - 1)) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                rnd_next_idx = '0;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (rnd_reg == (RND_W+1)'(NR)) state_next = ST_IDLE;
                else rnd_next_idx = rnd_reg[RND_W-1:0] + 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_KEXP && kidx_reg >= (RKW_IDX_W+1)'(NK))
            rk_mem[kidx_reg[RKW_IDX_W-1:2]][2'd3 - kidx_reg[1:0]] <= kw_new;
        else if (state_reg == ST_KEXP)
            rk_mem[kidx_reg[RKW_IDX_W-1:2]][2'd3 - kidx_reg[1:0]] <=
                win_reg[kidx_reg[$clog2(NK)-1:0]];
        rk_rd_reg <= rk_mem[rnd_next_idx];
    end

    logic [127:0] ks;
    logic [127:0] mask;
    always_comb begin
        ks = rnd_out ^ rk_rd_reg;
        for (int i = 0; i < BLOCK_BYTES; i++)
            mask[127 - 8*i -: 8] = (5'(i) < nvb_reg) ? 8'hff : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ctr_reg <= '0;
            out_valid_reg <= 1'b0;
            kidx_reg <= '0;
            rnd_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        data_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        nvb_reg <= s_axis_tdata[132:128];
                        last_reg <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            ctr_reg <= {iv_hi_reg, iv_lo_reg};
                            for (int i = 0; i < NK; i++)
                                win_reg[i] <= i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
                            kidx_reg <= '0;
                            rcon_reg <= 8'h01;
                        end
                    end
                end
                ST_KEXP: begin
                    kidx_reg <= kidx_reg + 1'b1;
                    if (kidx_reg >= (RKW_IDX_W+1)'(NK)) begin
                        for (int i = 0; i < NK-1; i++) win_reg[i] <= win_reg[i+1];
                        win_reg[NK-1] <= kw_new;
                        if (kmod == '0) rcon_reg <= xtime(rcon_reg);
                    end
                end
                ST_LOAD: begin
                    rnd_reg <= '0;
                    st_reg <= ctr_reg;
                end
                ST_RUN: begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == '0) st_reg <= st_reg ^ rk_rd_reg;
                    else st_reg <= ks;
                    if (rnd_reg == (RND_W+1)'(NR)) begin
                        out_data_reg <= {3'b000, nvb_reg,
                                         (data_reg ^ ks) & mask};
                        out_last_reg <= last_reg;
                        out_valid_reg <= 1'b1;
                        ctr_reg <= ctr_reg + 128'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // round 0 uses raw state for key add only
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_data_reg[135:128], out_data_reg[63:0], out_data_reg[127:64]} ;
    assign m_axis_tlast = out_last_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |=> out_valid_reg) else $error("result dropped");
    a_ctr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ctr_reg == $past(ctr_reg) + 128'd1) else $error("counter");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state");

endmodule
`default_nettype wire

// ----- tb/aes256_ctr_decrypt_top_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module aes256_ctr_decrypt_top_test
    import aes256_pkg::*;
();

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        last;
        logic        restart;
    } cipher_blk_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        last;
    } plain_blk_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = REG_KEY0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;

    aes256_ctr_decrypt_top u_top (.*);

    always #6 aclk = ~aclk;

    cipher_blk_t pending_blks[$];
    plain_blk_t  expected_plain[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    logic        taken = 1'b0;

    // shadow of the block's registers and state
    logic [63:0]  key_sh[4];
    logic [63:0]  iv_hi_sh, iv_lo_sh;
    logic [127:0] ctr_sh = '0;
    logic [31:0]  rkw[60];

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic void load_round_keys();
        logic [7:0]  rc;
        logic [31:0] t;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            rkw[i] = i[0] ? key_sh[i >> 1][31:0] : key_sh[i >> 1][63:32];
        for (int i = 8; i < 60; i++) begin
            t = rkw[i - 1];
            if (i % 8 == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end else if (i % 8 == 4) begin
                t = sbox_word(t);
            end
            rkw[i] = rkw[i - 8] ^ t;
        end
    endfunction

    function automatic logic [127:0] keystream_for(input logic [127:0] ctr);
        logic [7:0]   s[16];
        logic [7:0]   t[16];
        logic [7:0]   a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = ctr[127 - 8*i -: 8];
        for (int rnd = 0; rnd <= 14; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int rr = 0; rr < 4; rr++)
                        t[4*c + rr] = SBOX[s[4*((c + rr) % 4) + rr]];
                if (rnd < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        x = a0 ^ a1 ^ a2 ^ a3;
                        t[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
                        t[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
                        t[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
                        t[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
                    end
                end
                s = t;
            end
            for (int c = 0; c < 4; c++)
                for (int rr = 0; rr < 4; rr++)
                    s[4*c + rr] ^= rkw[rnd*4 + c][31 - 8*rr -: 8];
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic plain_blk_t decrypt_blk(input cipher_blk_t b);
        plain_blk_t   p;
        logic [127:0] ks, keep;
        int           n;
        if (b.restart) begin
            load_round_keys();
            ctr_sh = {iv_hi_sh, iv_lo_sh};
        end
        ks = keystream_for(ctr_sh);
        n = (b.nbytes > 16) ? 16 : b.nbytes;
        keep = '0;
        for (int i = 0; i < n; i++) keep[127 - 8*i -: 8] = 8'hff;
        {p.hi, p.lo} = ({b.hi, b.lo} ^ ks) & keep;
        p.nbytes = b.nbytes;
        p.last = b.last;
        ctr_sh = ctr_sh + 128'd1;
        return p;
    endfunction

    // input side: acceptance and prediction
    always @(posedge aclk) begin
        plain_blk_t p;
        taken <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            p = decrypt_blk({s_axis_tdata[63:0], s_axis_tdata[127:64],
                s_axis_tdata[132:128], s_axis_tlast, s_axis_tuser});
            expected_plain = {expected_plain, p};
        end
    end

    always @(negedge aclk) begin
        cipher_blk_t b;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || taken) begin
            if (pending_blks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_blks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b0, b.nbytes, b.lo, b.hi};
                s_axis_tlast <= b.last;
                s_axis_tuser <= b.restart;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        plain_blk_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_plain.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
                errors++;
            end else begin
                e = expected_plain.pop_front();
                if (m_axis_tdata[63:0] !== e.hi) begin
                    $display("%0t: plain_high exp %h got %h", $time, e.hi, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== e.lo) begin
                    $display("%0t: plain_low exp %h got %h", $time, e.lo, m_axis_tdata[127:64]);
                    errors++;
                end
                if (m_axis_tdata[132:128] !== e.nbytes) begin
                    $display("%0t: valid_bytes_out exp %0d got %0d", $time, e.nbytes,
                        m_axis_tdata[132:128]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: last_out exp %b got %b", $time, e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == REG_IV_HIGH) iv_hi_sh = val;
        else if (idx == REG_IV_LOW) iv_lo_sh = val;
        else key_sh[idx[1:0]] = val;
    endtask

    task automatic set_regs(input logic [63:0] k0, k1, k2, k3, ivh, ivl);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_IV_HIGH, ivh);
        write_reg(REG_IV_LOW, ivl);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_blks.size() == 0 && !s_axis_tvalid && expected_plain.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_blk(input cipher_blk_t b);
        pending_blks = {pending_blks, b};
    endtask

    task automatic queue_blk(input logic [4:0] n, input logic last, input logic rs);
        add_blk('{rnd64(), rnd64(), n, last, rs});
    endtask

    // mostly well-formed messages, some noise blocks
    task automatic queue_messages(input int count, input bit first_restart);
        int len;
        bit rs;
        rs = first_restart;
        while (count > 0) begin
            if ($urandom_range(9) == 0) begin
                queue_blk(5'($urandom_range(31)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
                count--;
            end else begin
                len = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6);
                for (int i = 0; i < len; i++)
                    queue_blk((i == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16,
                        i == len - 1, i == 0 && rs);
                count -= len;
            end
            rs = 1'b1;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // standard 256-bit test key, directed corners
        set_regs(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
            64'h18191a1b1c1d1e1f, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_blk('{64'h0, 64'h0, 5'd16, 1'b0, 1'b1});
        add_blk('{'1, '1, 5'd16, 1'b0, 1'b0});
        add_blk('{'1, '1, 5'd0, 1'b0, 1'b0});
        add_blk('{'1, '1, 5'd17, 1'b0, 1'b0});
        add_blk('{'1, '1, 5'd31, 1'b1, 1'b0});
        for (int n = 1; n <= 15; n++) queue_blk(5'(n), n == 15, 1'b0);
        add_blk('{'1, '1, 5'd8, 1'b1, 1'b1});
        drain();

        // counter wrap at 2^128 and carry into the upper half
        set_regs('1, '1, '1, '1, '1, 64'hffff_ffff_ffff_fffe);
        for (int i = 0; i < 4; i++) queue_blk(5'd16, i == 3, i == 0);
        drain();
        set_regs('0, '0, '0, '0, 64'h0, '1);
        for (int i = 0; i < 3; i++) queue_blk(5'd16, i == 2, i == 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 74 : 35) : 0;
            recv_stall_pct = (ph % 4 == 2) ? 74 : ((ph % 4 == 3) ? 35 : 0);
            set_regs(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
            // first message may keep the old keys and counter
            queue_messages(85, ph > 0 && $urandom_range(1));
            if (ph == 5) drain();
            queue_messages(85, 1'b1);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (80) @(posedge aclk);
        if (errors == 0 && expected_plain.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
